>>> src/vrpsu_pkg.sv
// Package for the video register port / scroll unit.
// Request codes, register numbers, mirroring modes, memory geometry and shared structs.
// No dependencies.
package vrpsu_pkg;

  typedef enum logic [3:0] {
    OP_READ   = 4'd0,
    OP_WRITE  = 4'd1,
    OP_DMA    = 4'd2,
    OP_INCX   = 4'd3,
    OP_INCY   = 4'd4,
    OP_COPYX  = 4'd5,
    OP_COPYY  = 4'd6,
    OP_VBLANK = 4'd7,
    OP_FCLR   = 4'd8,
    OP_FLAGS  = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    REG_CTRL    = 3'd0,
    REG_MASK    = 3'd1,
    REG_STATUS  = 3'd2,
    REG_OAMADDR = 3'd3,
    REG_OAMDATA = 3'd4,
    REG_SCROLL  = 3'd5,
    REG_ADDR    = 3'd6,
    REG_DATA    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    MIR_VERT   = 3'd0,
    MIR_HORIZ  = 3'd1,
    MIR_SGL_LO = 3'd2,
    MIR_SGL_HI = 3'd3,
    MIR_FOUR   = 3'd4
  } mirror_e;

  // where the read byte of a result comes from
  typedef enum logic [1:0] {
    RD_CONST   = 2'd0,
    RD_SPRITE  = 2'd1,
    RD_PALETTE = 2'd2
  } rdsrc_e;

  localparam int SprDepth = 256;
  localparam int SprAw    = 8;
  localparam int PatDepth = 8192;
  localparam int PatAw    = 13;
  localparam int PalDepth = 32;
  localparam int PalAw    = 5;
  localparam int PalDw    = 6;
  localparam int NtOffW   = 12;  // nametable offset before folding into the RAM size

  localparam logic [13:0] PalBase = 14'h3f00;

  typedef struct packed {
    logic               spr_we;
    logic               spr_re;
    logic [SprAw-1:0]   spr_addr;
    logic               pal_we;
    logic               pal_re;
    logic [PalAw-1:0]   pal_addr;
    logic               pat_we;
    logic               pat_re;
    logic [PatAw-1:0]   pat_addr;
    logic               nt_we;
    logic               nt_re;
    logic [NtOffW-1:0]  nt_off;
    logic [7:0]         wdata;
  } mem_req_t;

  typedef struct packed {
    rdsrc_e      rd_sel;
    logic [7:0]  rd_val;
    logic        pal_mask;
    logic        nmi;
    logic [14:0] vram_addr;
    logic [2:0]  fine_x;
    logic [7:0]  ctrl;
    logic [7:0]  mask;
  } res_t;

  // physical nametable offset under the mirroring mode
  function automatic logic [NtOffW-1:0] nt_offset(logic [2:0] mode, logic [11:0] a);
    logic [1:0] phys;
    begin
      unique case (mode)
        MIR_VERT:   phys = {1'b0, a[10]};
        MIR_HORIZ:  phys = {1'b0, a[11]};
        MIR_SGL_LO: phys = 2'd0;
        MIR_SGL_HI: phys = 2'd1;
        default:    phys = a[11:10];
      endcase
      nt_offset = {phys, a[9:0]};
    end
  endfunction

  // palette slot with the backdrop aliases folded down
  function automatic logic [PalAw-1:0] pal_slot(logic [4:0] a);
    begin
      if (a[4] && (a[1:0] == 2'b00)) pal_slot = {1'b0, a[3:0]};
      else pal_slot = a;
    end
  endfunction

endpackage

>>> src/vrpsu_ram.sv
// Generic single-port synchronous RAM, registered read data.
// No dependencies.
module vrpsu_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/vrpsu_regs.sv
// Register file and scroll logic: decodes requests, updates the registers, issues RAM accesses.
// Depends on vrpsu_pkg.
module vrpsu_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_mode_i,
  input  logic               acc_i,
  input  logic [3:0]         op_i,
  input  logic [2:0]         reg_sel_i,
  input  logic [7:0]         data_in_i,
  input  logic [7:0]         oam_index_i,
  input  logic [7:0]         pat_rdata_i,
  input  logic [7:0]         nt_rdata_i,
  output vrpsu_pkg::mem_req_t req_o,
  output vrpsu_pkg::res_t     res_o
);
  import vrpsu_pkg::*;

  logic [2:0]  mode_q;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  oam_ptr_q, oam_ptr_d;
  logic [14:0] cur_q, cur_d;
  logic [14:0] tmp_q, tmp_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  latch_q, latch_d;
  // read buffer lives in the pattern/nametable read-data registers
  logic        buf_vld_q, buf_vld_d;
  logic        buf_nt_q, buf_nt_d;

  logic [7:0]  buf_data;
  logic [13:0] a14;
  logic [14:0] step;
  logic [4:0]  y;
  logic [11:0] nt_off;

  assign buf_data = !buf_vld_q ? 8'h00 : (buf_nt_q ? nt_rdata_i : pat_rdata_i);
  assign a14      = cur_q[13:0];
  assign step     = cur_q + (ctrl_q[2] ? 15'd32 : 15'd1);
  assign nt_off   = nt_offset(mode_q, a14[11:0]);

  always_comb begin
    ctrl_d    = ctrl_q;
    mask_d    = mask_q;
    status_d  = status_q;
    oam_ptr_d = oam_ptr_q;
    cur_d     = cur_q;
    tmp_d     = tmp_q;
    fine_x_d  = fine_x_q;
    toggle_d  = toggle_q;
    latch_d   = latch_q;
    buf_vld_d = buf_vld_q;
    buf_nt_d  = buf_nt_q;
    y         = cur_q[9:5];
    req_o     = '0;
    req_o.wdata    = data_in_i;
    req_o.spr_addr = oam_ptr_q;
    req_o.pal_addr = pal_slot(a14[4:0]);
    req_o.pat_addr = a14[12:0];
    req_o.nt_off   = nt_off;
    res_o          = '0;
    res_o.rd_sel   = RD_CONST;
    res_o.pal_mask = mask_q[0];

    unique case (op_i)
      OP_READ: begin
        unique case (reg_sel_i)
          REG_STATUS: begin
            res_o.rd_val = {status_q, latch_q[4:0]};
            status_d[2]  = 1'b0;
            toggle_d     = 1'b0;
          end
          REG_OAMDATA: begin
            res_o.rd_sel = RD_SPRITE;
            req_o.spr_re = 1'b1;
          end
          REG_DATA: begin
            buf_vld_d = 1'b1;
            if (a14 >= PalBase) begin
              res_o.rd_sel = RD_PALETTE;
              req_o.pal_re = 1'b1;
              // refill from the nametable beneath the palette
              req_o.nt_re  = 1'b1;
              buf_nt_d     = 1'b1;
            end else begin
              res_o.rd_val = buf_data;
              req_o.pat_re = !a14[13];
              req_o.nt_re  = a14[13];
              buf_nt_d     = a14[13];
            end
            cur_d = step;
          end
          default: res_o.rd_val = latch_q;
        endcase
      end
      OP_WRITE: begin
        latch_d = data_in_i;
        unique case (reg_sel_i)
          REG_CTRL: begin
            res_o.nmi     = !ctrl_q[7] && data_in_i[7] && status_q[2];
            ctrl_d        = data_in_i;
            tmp_d[11:10]  = data_in_i[1:0];
          end
          REG_MASK:    mask_d = data_in_i;
          REG_OAMADDR: oam_ptr_d = data_in_i;
          REG_OAMDATA: begin
            req_o.spr_we = 1'b1;
            oam_ptr_d    = oam_ptr_q + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle_q) begin
              fine_x_d   = data_in_i[2:0];
              tmp_d[4:0] = data_in_i[7:3];
            end else begin
              tmp_d[14:12] = data_in_i[2:0];
              tmp_d[9:5]   = data_in_i[7:3];
            end
            toggle_d = !toggle_q;
          end
          REG_ADDR: begin
            if (!toggle_q) begin
              tmp_d[14]   = 1'b0;
              tmp_d[13:8] = data_in_i[5:0];
            end else begin
              tmp_d[7:0] = data_in_i;
              cur_d      = {tmp_q[14:8], data_in_i};
            end
            toggle_d = !toggle_q;
          end
          REG_DATA: begin
            if (a14 >= PalBase) req_o.pal_we = 1'b1;
            else if (a14[13]) req_o.nt_we = 1'b1;
            else req_o.pat_we = 1'b1;
            cur_d = step;
          end
          default: ;
        endcase
      end
      OP_DMA: begin
        req_o.spr_we   = 1'b1;
        req_o.spr_addr = oam_index_i;
      end
      OP_INCX: begin
        if (cur_q[4:0] == 5'd31) begin
          cur_d[4:0] = 5'd0;
          cur_d[10]  = !cur_q[10];
        end else begin
          cur_d = cur_q + 15'd1;
        end
      end
      OP_INCY: begin
        if (cur_q[14:12] != 3'd7) begin
          cur_d[14:12] = cur_q[14:12] + 3'd1;
        end else begin
          cur_d[14:12] = 3'd0;
          if (cur_q[9:5] == 5'd29) begin
            y         = 5'd0;
            cur_d[11] = !cur_q[11];
          end else if (cur_q[9:5] == 5'd31) begin
            y = 5'd0;
          end else begin
            y = cur_q[9:5] + 5'd1;
          end
          cur_d[9:5] = y;
        end
      end
      OP_COPYX: begin
        cur_d[10]  = tmp_q[10];
        cur_d[4:0] = tmp_q[4:0];
      end
      OP_COPYY: begin
        cur_d[14:11] = tmp_q[14:11];
        cur_d[9:5]   = tmp_q[9:5];
      end
      OP_VBLANK: begin
        status_d[2] = 1'b1;
        res_o.nmi   = ctrl_q[7];
      end
      OP_FCLR: status_d = 3'd0;
      OP_FLAGS: begin
        status_d[1] = status_q[1] | data_in_i[6];
        status_d[0] = status_q[0] | data_in_i[5];
      end
      default: ;
    endcase

    if (!acc_i) begin
      req_o = '0;
    end

    res_o.vram_addr = cur_d;
    res_o.fine_x    = fine_x_d;
    res_o.ctrl      = ctrl_d;
    res_o.mask      = mask_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MIR_VERT;
      ctrl_q    <= '0;
      mask_q    <= '0;
      status_q  <= '0;
      oam_ptr_q <= '0;
      cur_q     <= '0;
      tmp_q     <= '0;
      fine_x_q  <= '0;
      toggle_q  <= 1'b0;
      latch_q   <= '0;
      buf_vld_q <= 1'b0;
      buf_nt_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      if (acc_i) begin
        ctrl_q    <= ctrl_d;
        mask_q    <= mask_d;
        status_q  <= status_d;
        oam_ptr_q <= oam_ptr_d;
        cur_q     <= cur_d;
        tmp_q     <= tmp_d;
        fine_x_q  <= fine_x_d;
        toggle_q  <= toggle_d;
        latch_q   <= latch_d;
        buf_vld_q <= buf_vld_d;
        buf_nt_q  <= buf_nt_d;
      end
    end
  end

endmodule

>>> src/video_register_port_scroll_unit.sv
// Top level of the video register port / scroll unit: RAMs, result pipeline, handshakes.
// Depends on vrpsu_pkg, vrpsu_regs and vrpsu_ram.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------------
//   cfg      | in        | cfg_valid_i / cfg_ready_o  | cfg_mirroring_mode_i
//   in       | in        | in_valid_i  / in_ready_o   | op_i reg_sel_i data_in_i oam_index_i
//   out      | out       | out_valid_o / out_ready_i  | read_data_o nmi_o vram_addr_o
//            |           |                            | fine_x_out_o ctrl_out_o mask_out_o
//
// One request per clock while in_ready_o is high. A request updates the registers
// and issues its RAM access at the accept edge, which also registers the RAM read
// data. The result then moves from the read stage into the output register once that
// register is free or being drained, and out_valid_o rises as it is loaded. The two
// stages absorb output stalls without a bubble; in_ready_o drops only when both hold results.
// Reset clears the registers and control; RAM contents are left as they are.
// Configuration writes are always taken (cfg_ready_o is tied high).
module video_register_port_scroll_unit #(
  parameter int NAMETABLE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_mirroring_mode_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  op_i,
  input  logic [2:0]  reg_sel_i,
  input  logic [7:0]  data_in_i,
  input  logic [7:0]  oam_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        nmi_o,
  output logic [14:0] vram_addr_o,
  output logic [2:0]  fine_x_out_o,
  output logic [7:0]  ctrl_out_o,
  output logic [7:0]  mask_out_o
);
  import vrpsu_pkg::*;

  localparam int          NtAw    = $clog2(NAMETABLE_BYTES);
  localparam logic [12:0] NtBytes = 13'(NAMETABLE_BYTES);

  logic       in_acc;
  logic       s1_move;
  logic       s1_valid_q, s1_valid_d;
  logic       s2_valid_q, s2_valid_d;
  res_t       s1_res_q;
  res_t       res;
  mem_req_t   req;

  logic [7:0]       spr_rdata;
  logic [PalDw-1:0] pal_rdata;
  logic [7:0]       pat_rdata;
  logic [7:0]       nt_rdata;
  logic [12:0]      nt_wide;
  logic [12:0]      nt_fold;
  logic [7:0]       rd_byte;

  logic [7:0]  read_data_q;
  logic        nmi_q;
  logic [14:0] vram_addr_q;
  logic [2:0]  fine_x_q;
  logic [7:0]  ctrl_out_q;
  logic [7:0]  mask_out_q;

  assign cfg_ready_o = 1'b1;

  // read stage advances when the output register is free or being drained
  assign s1_move    = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;

  vrpsu_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_mode_i  (cfg_mirroring_mode_i),
    .acc_i       (in_acc),
    .op_i        (op_i),
    .reg_sel_i   (reg_sel_i),
    .data_in_i   (data_in_i),
    .oam_index_i (oam_index_i),
    .pat_rdata_i (pat_rdata),
    .nt_rdata_i  (nt_rdata),
    .req_o       (req),
    .res_o       (res)
  );

  // fold the nametable offset into the RAM size; offset stays below twice the size
  assign nt_wide = {1'b0, req.nt_off};
  assign nt_fold = (nt_wide >= NtBytes) ? (nt_wide - NtBytes) : nt_wide;

  vrpsu_ram #(.Depth(SprDepth), .Width(8)) u_spr_ram (
    .clk_i   (clk_i),
    .we_i    (req.spr_we),
    .re_i    (req.spr_re),
    .addr_i  (req.spr_addr),
    .wdata_i (req.wdata),
    .rdata_o (spr_rdata)
  );

  vrpsu_ram #(.Depth(PalDepth), .Width(PalDw)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (req.pal_we),
    .re_i    (req.pal_re),
    .addr_i  (req.pal_addr),
    .wdata_i (req.wdata[PalDw-1:0]),
    .rdata_o (pal_rdata)
  );

  vrpsu_ram #(.Depth(PatDepth), .Width(8)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (req.pat_we),
    .re_i    (req.pat_re),
    .addr_i  (req.pat_addr),
    .wdata_i (req.wdata),
    .rdata_o (pat_rdata)
  );

  vrpsu_ram #(.Depth(NAMETABLE_BYTES), .Width(8)) u_nt_ram (
    .clk_i   (clk_i),
    .we_i    (req.nt_we),
    .re_i    (req.nt_re),
    .addr_i  (nt_fold[NtAw-1:0]),
    .wdata_i (req.wdata),
    .rdata_o (nt_rdata)
  );

  // read byte resolved once the RAM data is in; rdata holds while stage 1 stalls
  always_comb begin
    case (s1_res_q.rd_sel)
      RD_SPRITE:  rd_byte = spr_rdata;
      RD_PALETTE: rd_byte = {{(8-PalDw){1'b0}}, pal_rdata} &
                            (s1_res_q.pal_mask ? 8'h30 : 8'hff);
      default:    rd_byte = s1_res_q.rd_val;
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) s1_valid_d = 1'b1;
    else if (s1_move) s1_valid_d = 1'b0;
    s2_valid_d = s2_valid_q;
    if (s1_move) s2_valid_d = 1'b1;
    else if (out_ready_i) s2_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      read_data_q <= rd_byte;
      nmi_q       <= s1_res_q.nmi;
      vram_addr_q <= s1_res_q.vram_addr;
      fine_x_q    <= s1_res_q.fine_x;
      ctrl_out_q  <= s1_res_q.ctrl;
      mask_out_q  <= s1_res_q.mask;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign read_data_o  = read_data_q;
  assign nmi_o        = nmi_q;
  assign vram_addr_o  = vram_addr_q;
  assign fine_x_out_o = fine_x_q;
  assign ctrl_out_o   = ctrl_out_q;
  assign mask_out_o   = mask_out_q;

endmodule
